@@ rtl/ffpa_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffpa_pkg
// Shared widths, codes and the token that travels down the page cell chain.
// ============================================================================
package ffpa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;

    // Pages held by one cell and number of cells in the chain
    localparam int CELL_PAGES = (NUM_PAGES < 32) ? NUM_PAGES : 32;
    localparam int NUM_CELLS  = (NUM_PAGES + CELL_PAGES - 1) / CELL_PAGES;
    localparam int CELL_W     = (CELL_PAGES > 1) ? $clog2(CELL_PAGES) : 1;
    localparam int CID_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LIM_W      = $clog2(NUM_PAGES + 1);

    // Field widths
    localparam int FUNC_W     = 3;
    localparam int ADDR_W     = 32;
    localparam int QPAGE_W    = 10;
    localparam int RADDR_W    = 22;
    localparam int KIND_W     = 2;
    localparam int STAT_W     = 2;
    localparam int TOTAL_W    = 11;
    localparam int RSV_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_INIT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MARK   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;

    // Page kinds
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_USER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYSTEM = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STAT_W-1:0] ST_UNALIGNED = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PAGES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_FIRST     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RSV_LAST      = 2'd2;

    // Operation token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [FUNC_W-1:0]   op;
        logic                hit;     // target page is inside the managed range
        logic [PG_W-1:0]     page;    // target page, or allocated page
        logic                found;   // allocate already served by an earlier cell
        logic [KIND_W-1:0]   kind;    // query answer
        logic [STAT_W-1:0]   status;
    } tok_t;

    // Limits shared by all cells
    typedef struct packed {
        logic [LIM_W-1:0]    lim;
        logic [RSV_W-1:0]    rsv_first;
        logic [RSV_W-1:0]    rsv_last;
    } cell_cfg_t;

endpackage

@@ rtl/ffpa_req_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffpa_req_if
// Request channel: one allocator operation per transfer.
// ============================================================================
interface ffpa_req_if
    import ffpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [ADDR_W-1:0]   address;
    logic [QPAGE_W-1:0]  page_index;

    modport source (output valid, output func, output address, output page_index,
                    input ready);
    modport sink   (input valid, input func, input address, input page_index,
                    output ready);
endinterface

@@ rtl/ffpa_rsp_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffpa_rsp_if
// Response channel: one result per operation.
// ============================================================================
interface ffpa_rsp_if
    import ffpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [RADDR_W-1:0]  result_address;
    logic [KIND_W-1:0]   page_kind;
    logic [STAT_W-1:0]   status;

    modport source (output valid, output result_address, output page_kind,
                    output status, input ready);
    modport sink   (input valid, input result_address, input page_kind,
                    input status, output ready);
endinterface

@@ rtl/ffpa_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ffpa_cell
// One link of the page chain: holds the kinds of CELL_PAGES pages, applies
// the passing token to them and registers the token for the next cell.
// ============================================================================
module ffpa_cell
    import ffpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [CID_W-1:0]  cell_id,
    input  cell_cfg_t         cfg,
    input  tok_t              tok_in,
    output tok_t              tok_out
);

    logic [KIND_W-1:0] kind_reg  [CELL_PAGES];
    logic [KIND_W-1:0] kind_next [CELL_PAGES];
    tok_t              tok_reg;
    tok_t              tok_next;

    logic [31:0]       pg_num [CELL_PAGES];
    logic [CELL_PAGES-1:0] in_lim;
    logic [CELL_PAGES-1:0] free_vec;
    logic              any_free;
    logic [CELL_W-1:0] first_idx;
    logic              own_page;
    logic [CELL_W-1:0] local_idx;

    always_comb
    begin
        for (int i = 0; i < CELL_PAGES; i++)
        begin
            pg_num[i]   = (32'(cell_id) << CELL_W) + 32'(i);
            in_lim[i]   = pg_num[i] < 32'(cfg.lim);
            free_vec[i] = in_lim[i] && (kind_reg[i] == KIND_FREE);
        end

        // lowest free page of this cell
        any_free  = 1'b0;
        first_idx = '0;
        for (int i = CELL_PAGES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                any_free  = 1'b1;
                first_idx = CELL_W'(i);
            end
        end

        own_page  = tok_in.hit && ((32'(tok_in.page) >> CELL_W) == 32'(cell_id));
        local_idx = tok_in.page[CELL_W-1:0];

        tok_next  = tok_in;
        kind_next = kind_reg;

        case (tok_in.op)
            FUNC_INIT:
            begin
                for (int i = 0; i < CELL_PAGES; i++)
                begin
                    if (in_lim[i] && (pg_num[i] >= 32'(cfg.rsv_first))
                        && (pg_num[i] <= 32'(cfg.rsv_last)))
                        kind_next[i] = KIND_SYSTEM;
                    else
                        kind_next[i] = KIND_FREE;
                end
            end
            FUNC_ALLOC:
            begin
                if (!tok_in.found && any_free)
                begin
                    kind_next[first_idx] = KIND_USER;
                    tok_next.found       = 1'b1;
                    tok_next.page        = PG_W'((32'(cell_id) << CELL_W) + 32'(first_idx));
                end
            end
            FUNC_FREE:
            begin
                if (own_page)
                    kind_next[local_idx] = KIND_FREE;
            end
            FUNC_MARK:
            begin
                if (own_page)
                    kind_next[local_idx] = KIND_SYSTEM;
            end
            FUNC_QUERY:
            begin
                if (own_page)
                    tok_next.kind = kind_reg[local_idx];
            end
            default:
            begin
                tok_next = tok_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            for (int i = 0; i < CELL_PAGES; i++)
                kind_reg[i] <= KIND_FREE;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
            if (tok_in.valid)
                kind_reg <= kind_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

@@ rtl/first_free_page_allocator_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// first_free_page_allocator_top
// First-fit page frame allocator built as a chain of page cells.
// ============================================================================
// Flow: the request is registered in the launch register, then in each cell
//   in turn, and last in the response register.
// Throughput: one operation at a time; the token walks the cell chain one cell
//   per cycle while the chain is not held; a new request enters after it leaves.
// Reset: asynchronous, active low; all pages free, total_pages 1024, reserved
//   range 0..0, no operation in flight.
// ============================================================================
module first_free_page_allocator_top
    import ffpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ffpa_req_if.sink               req,
    ffpa_rsp_if.source             rsp
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TOTAL_W-1:0] total_pages_reg;
    logic [RSV_W-1:0]   rsv_first_reg;
    logic [RSV_W-1:0]   rsv_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= TOTAL_W'(1024);
            rsv_first_reg   <= '0;
            rsv_last_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_PAGES: total_pages_reg <= cfg_data[TOTAL_W-1:0];
                CFG_RSV_FIRST:   rsv_first_reg   <= cfg_data[RSV_W-1:0];
                CFG_RSV_LAST:    rsv_last_reg    <= cfg_data[RSV_W-1:0];
                default:         ; // unused index: drop the write
            endcase
        end
    end

    // Clamp the managed page count to the pages that exist
    cell_cfg_t cell_cfg;

    always_comb
    begin
        cell_cfg.lim       = (32'(total_pages_reg) > 32'(NUM_PAGES)) ?
                             LIM_W'(NUM_PAGES) : LIM_W'(total_pages_reg);
        cell_cfg.rsv_first = rsv_first_reg;
        cell_cfg.rsv_last  = rsv_last_reg;
    end

    // ------------------------------------------------------------------
    // Flow control
    // ------------------------------------------------------------------
    tok_t  tok [NUM_CELLS + 1];
    tok_t  launch_reg;
    tok_t  launch_next;
    tok_t  last_tok;
    logic  busy_reg;
    logic  advance;
    logic  req_xfer;
    logic  rsp_xfer;

    logic                out_valid_reg;
    logic [RADDR_W-1:0]  out_addr_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [STAT_W-1:0]   out_status_reg;

    assign last_tok = tok[NUM_CELLS];

    // Hold the whole chain only while a finished token would land on an
    // untaken response.
    assign advance  = !(last_tok.valid && out_valid_reg && !rsp.ready);
    assign req.ready = !busy_reg;
    assign req_xfer = req.valid && req.ready;
    assign rsp_xfer = rsp.valid && rsp.ready;

    // ------------------------------------------------------------------
    // Build the launch token: range and alignment are decided up front
    // ------------------------------------------------------------------
    logic [31:0] addr_page;
    logic        addr_hit;
    logic        qry_hit;
    logic        unaligned;

    always_comb
    begin
        addr_page = req.address >> PAGE_SHIFT;
        addr_hit  = addr_page < 32'(cell_cfg.lim);
        qry_hit   = 32'(req.page_index) < 32'(cell_cfg.lim);
        unaligned = (req.address & ((32'd1 << PAGE_SHIFT) - 32'd1)) != 32'd0;

        launch_next        = '0;
        launch_next.valid  = 1'b1;
        launch_next.op     = req.func;
        launch_next.status = ST_OK;

        case (req.func)
            FUNC_FREE:
            begin
                launch_next.hit  = addr_hit;
                launch_next.page = PG_W'(addr_page);
                if (!addr_hit)
                    launch_next.status = ST_RANGE;
                else if (unaligned)
                    launch_next.status = ST_UNALIGNED;
            end
            FUNC_MARK:
            begin
                launch_next.hit  = addr_hit;
                launch_next.page = PG_W'(addr_page);
                if (!addr_hit)
                    launch_next.status = ST_RANGE;
            end
            FUNC_QUERY:
            begin
                launch_next.hit  = qry_hit;
                launch_next.page = PG_W'(req.page_index);
                if (!qry_hit)
                    launch_next.status = ST_RANGE;
            end
            default:
            begin
                launch_next.hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= '0;
            busy_reg   <= 1'b0;
        end
        else
        begin
            if (req_xfer)
                launch_reg <= launch_next;
            else if (advance)
                launch_reg.valid <= 1'b0;

            // busy from request transfer until the token leaves the chain
            if (req_xfer)
                busy_reg <= 1'b1;
            else if (last_tok.valid && advance)
                busy_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: each cell applies the token to its pages, then passes it on
    // ------------------------------------------------------------------
    assign tok[0] = launch_reg;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        ffpa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .cell_id (CID_W'(g)),
            .cfg     (cell_cfg),
            .tok_in  (tok[g]),
            .tok_out (tok[g + 1])
        );
    end

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    logic               alloc_ok;
    logic               alloc_miss;
    logic [RADDR_W-1:0] alloc_addr;
    logic [STAT_W-1:0]  final_status;

    always_comb
    begin
        alloc_ok     = (last_tok.op == FUNC_ALLOC) && last_tok.found;
        alloc_miss   = (last_tok.op == FUNC_ALLOC) && !last_tok.found;
        alloc_addr   = RADDR_W'(64'(last_tok.page) << PAGE_SHIFT);
        final_status = alloc_miss ? ST_NO_FREE : last_tok.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (last_tok.valid && advance)
            out_valid_reg <= 1'b1;
        else if (rsp_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (last_tok.valid && advance)
        begin
            out_addr_reg   <= alloc_ok ? alloc_addr : '0;
            out_kind_reg   <= last_tok.kind;
            out_status_reg <= final_status;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.page_kind      = out_kind_reg;
    assign rsp.status         = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic [NUM_CELLS:0] tok_valids;

    always_comb
    begin
        for (int i = 0; i <= NUM_CELLS; i++)
            tok_valids[i] = tok[i].valid;
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valids) <= 1)
        else $error("more than one operation in the cell chain");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (tok_valids == '0))
        else $error("token in the chain while not busy");

    a_rsp_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg))
        else $error("response without an operation in flight");

    a_no_free_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_NO_FREE)) |-> (out_addr_reg == '0))
        else $error("failed allocate returned an address");

endmodule
